[design/jump_search_engine_macros.svh]
// Assertion macros shared by the jump search engine.
`ifndef JUMP_SEARCH_ENGINE_MACROS_SVH
`define JUMP_SEARCH_ENGINE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define JSE_ASSERT_NOW(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/jse_pkg.sv]
package jse_pkg;

	localparam int VALUE_BITS = 32;
	localparam int POS_BITS   = 10;
	localparam int CMD_BITS   = 2;

	localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd2;

	typedef struct packed {
		logic [CMD_BITS-1:0]          command;
		logic signed [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                found;
		logic [POS_BITS-1:0] position;
		logic                status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // request taken while idle
		logic probe_run;  // issue the next block-end probe
		logic scan_init;  // set up the scan of the selected block
		logic scan_run;   // issue the next scan read
		logic finish;     // write the search result
		logic found;      // search result flag for finish
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic probe_hit;
		logic probe_past;
		logic scan_match;
		logic scan_last;
	} ctl_sts_t;

endpackage

[design/jse_datapath.sv]
module jse_datapath #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  jse_pkg::req_t    request,
	input  jse_pkg::ctl_cmd_t cmd,
	output jse_pkg::ctl_sts_t sts,
	output jse_pkg::rsp_t    result
);
	import jse_pkg::*;

	localparam int AW       = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int BL_BITS  = (CNT_BITS + 1) / 2;
	localparam int SQ_BITS  = 2 * BL_BITS + 2;

	logic signed [VALUE_BITS-1:0] mem [DEPTH];
	logic signed [VALUE_BITS-1:0] rdata_s1;
	logic signed [VALUE_BITS-1:0] target_q;

	logic [CNT_BITS-1:0] count_q;
	logic [BL_BITS-1:0]  bl_q;
	logic [CNT_BITS:0]   step_q;
	logic [CNT_BITS-1:0] idx_q;
	logic [CNT_BITS-1:0] end_q;
	logic                pend_v_s1;
	logic [CNT_BITS:0]   pend_pos_s1;
	rsp_t                result_q;

	logic [CNT_BITS:0]   count_ext;
	logic [CNT_BITS:0]   bl_ext;
	logic [CNT_BITS-1:0] probe_end;
	logic [CNT_BITS-1:0] probe_addr;
	logic [CNT_BITS:0]   scan_start;
	logic [CNT_BITS-1:0] scan_end;
	logic [AW-1:0]       raddr;
	logic                full;
	logic                do_write;
	logic [BL_BITS:0]    bl_inc;
	logic [SQ_BITS-1:0]  bl_inc_sq;
	logic [SQ_BITS-1:0]  count_next_ext;

	assign count_ext  = {1'b0, count_q};
	assign bl_ext     = (CNT_BITS + 1)'(bl_q);
	assign full       = (count_ext >= (CNT_BITS + 1)'(DEPTH));
	assign do_write   = cmd.load && (request.command == CMD_APPEND) && !full;

	// Block end of the probe being issued, clamped to the element count.
	assign probe_end  = (step_q < count_ext) ? step_q[CNT_BITS-1:0] : count_q;
	assign probe_addr = probe_end - 1'b1;
	assign scan_start = pend_pos_s1 - bl_ext;
	assign scan_end   = (pend_pos_s1 < count_ext) ? pend_pos_s1[CNT_BITS-1:0] : count_q;
	assign raddr      = cmd.scan_run ? idx_q[AW-1:0] : probe_addr[AW-1:0];

	// The block length steps up when the new count reaches the next square.
	assign bl_inc         = {1'b0, bl_q} + 1'b1;
	assign bl_inc_sq      = SQ_BITS'(bl_inc) * SQ_BITS'(bl_inc);
	assign count_next_ext = SQ_BITS'(count_q) + SQ_BITS'(1);

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[count_q[AW-1:0]] <= request.value;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			bl_q      <= '0;
			pend_v_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				pend_v_s1 <= 1'b0;
				if (request.command == CMD_CLEAR) begin
					count_q <= '0;
					bl_q    <= '0;
				end else if (do_write) begin
					count_q <= count_q + 1'b1;
					if (bl_inc_sq == count_next_ext) begin
						bl_q <= bl_inc[BL_BITS-1:0];
					end
				end
			end else if (cmd.probe_run) begin
				pend_v_s1 <= 1'b1;
			end else if (cmd.scan_init) begin
				pend_v_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				pend_v_s1 <= (idx_q < end_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q <= request.value;
			step_q   <= bl_ext;
			result_q <= '{found: 1'b0, position: '0,
				status: (request.command == CMD_APPEND) && full};
		end
		if (cmd.probe_run) begin
			step_q      <= step_q + bl_ext;
			pend_pos_s1 <= step_q;
		end
		if (cmd.scan_init) begin
			idx_q <= scan_start[CNT_BITS-1:0];
			end_q <= scan_end;
		end
		if (cmd.scan_run) begin
			idx_q       <= idx_q + 1'b1;
			pend_pos_s1 <= {1'b0, idx_q};
		end
		if (cmd.finish) begin
			result_q <= '{found: cmd.found,
				position: cmd.found ? POS_BITS'(pend_pos_s1) : '0,
				status: 1'b0};
		end
	end

	always_comb begin
		sts            = '0;
		sts.empty      = (count_q == '0);
		sts.probe_hit  = pend_v_s1 && (rdata_s1 >= target_q);
		sts.probe_past = pend_v_s1 && !(rdata_s1 >= target_q) && (pend_pos_s1 >= count_ext);
		sts.scan_match = pend_v_s1 && (rdata_s1 == target_q);
		sts.scan_last  = pend_v_s1 && ((pend_pos_s1 + 1'b1) >= {1'b0, end_q});
	end

	assign result = result_q;

endmodule

[design/jse_ctrl.sv]
module jse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [jse_pkg::CMD_BITS-1:0] command,
	input  jse_pkg::ctl_sts_t sts,
	output jse_pkg::ctl_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import jse_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PROBE = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       done_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if ((command == CMD_SEARCH) && !sts.empty) begin
						state_d = S_PROBE;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			S_PROBE: begin
				priority if (sts.probe_hit) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else if (sts.probe_past) begin
					cmd.finish = 1'b1;
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.probe_run = 1'b1;
				end
			end
			S_SCAN: begin
				priority if (sts.scan_match) begin
					cmd.finish = 1'b1;
					cmd.found  = 1'b1;
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end else if (sts.scan_last) begin
					cmd.finish = 1'b1;
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

[design/jump_search_engine.sv]
// Jump search engine over a store of signed values appended in ascending order.
// A request is taken on a rising edge with start high and busy low. Its
// command clears the store, appends request.value, or searches for it.
// Every request gives one result on result, flagged by done, which is high
// for a single cycle; the receiver must take it then and cannot stall it.
// Clear, append and unused commands: done rises the cycle after the request,
// busy stays low, so one such request can be taken every cycle.
// A search probes the last element of each block of floor(sqrt(count))
// values, then scans the chosen block, one memory read per cycle through
// the single read port. busy stays high until the cycle done rises.
// A search of an empty store answers like a clear, in the next cycle.
// Reset empties the store and the block length; the memory itself is not
// swept, since only reads of positions below the count are ever used.
`include "jump_search_engine_macros.svh"

module jump_search_engine #(
	parameter int DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  jse_pkg::req_t request,
	output logic          busy,
	output logic          done,
	output jse_pkg::rsp_t result
);
	import jse_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	jse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	jse_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

	`JSE_ASSERT_NOW(a_done_has_request, clk, arst_n, done, $past(busy) || $past(start), "result without a request")
	`JSE_ASSERT_NOW(a_done_frees, clk, arst_n, done, !busy, "busy still high with the result")
	`JSE_ASSERT_NEXT(a_short_cmd_one_cycle, clk, arst_n, start && !busy && (request.command != CMD_SEARCH), done && !busy, "clear or append result late")
	`JSE_ASSERT_NOW(a_status_only_append, clk, arst_n, done && result.status, $past(request.command) == CMD_APPEND, "status set for a non-append request")

endmodule
